/* sv/bitmap_frame_allocator_top_assert.svh */
// Assertion macros for the bitmap frame allocator checker.
// Every macro samples on clk_i and is held off while rst_ni is low.
`ifndef BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap frame allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap frame allocator check failed");

`endif

/* sv/bfa_pkg.sv */
// Shared constants, command and status codes and interface structs of the
// bitmap frame allocator. No dependencies.
package bfa_pkg;

  localparam int unsigned NUM_FRAMES = 16384;
  localparam int unsigned FRAME_W    = 14;  // frame index bits
  localparam int unsigned CNT_W      = 15;  // frame count bits (holds NUM_FRAMES)
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned WORD_SEL_W = 6;
  localparam int unsigned NUM_WORDS  = NUM_FRAMES / WORD_W;
  localparam int unsigned WIDX_W     = FRAME_W - WORD_SEL_W;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned XLEN       = 64;
  localparam int unsigned TYPE_W     = 32;
  localparam int unsigned ADDR_W     = 26;
  localparam int unsigned BYTES_W    = 27;
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned POP_W      = 7;

  localparam logic [CFG_W-1:0]  RESERVE_RESET = 15'd512;
  localparam logic [TYPE_W-1:0] USABLE_TYPE   = 32'd1;

  localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FREE   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FRAME = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   op;
    logic               usable;
    logic               range_ok;
    logic [CNT_W-1:0]   start_frame;
    logic [CNT_W-1:0]   stop_frame;
    logic               free_ok;
    logic [FRAME_W-1:0] free_frame;
  } bfa_cmd_t;

  typedef struct packed {
    logic     valid;
    bfa_cmd_t cmd;
  } bfa_q_t;

  typedef struct packed {
    logic pop;
    logic init_done;
  } bfa_bk_t;

endpackage

/* sv/bitmap_frame_allocator_top.sv */
// Top level of the bitmap frame allocator: front decoder and queue, back
// bitmap engine. Uses bfa_pkg, bfa_front and bfa_back.
//
// Usage:
//   Commands enter on start/busy: a command is taken at a clock edge with
//   start high and busy low. The front decodes it into frame numbers and
//   queues up to two commands; the back runs them one at a time.
//   Each command gives exactly one result, shown for one cycle with
//   result_valid_o high; the receiver must take it then.
//   Work per command in the back:
//     unknown command, empty region, out-of-range free: no bitmap access
//     free: one bitmap word; add region: each bitmap word touched
//     allocate: each word scanned until a free frame
//     begin map and finish map: one pass over all 256 words
//   The back finishes each command before it takes the next one;
//   the bitmap has one read and one write port per cycle.
//   After reset the back writes every bitmap word to "used",
//   with busy held high; the configuration port stays open. Write
//   reserve_low_frames only while no command is outstanding.
module bitmap_frame_allocator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [bfa_pkg::CMD_W-1:0]    command_i,
  input  logic [bfa_pkg::XLEN-1:0]     region_base_i,
  input  logic [bfa_pkg::XLEN-1:0]     region_length_i,
  input  logic [bfa_pkg::TYPE_W-1:0]   region_type_i,
  input  logic [bfa_pkg::XLEN-1:0]     free_address_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bfa_pkg::CFG_W-1:0]    cfg_reserve_low_frames_i,
  output logic                        result_valid_o,
  output logic [bfa_pkg::STAT_W-1:0]   status_o,
  output logic [bfa_pkg::ADDR_W-1:0]   frame_address_o,
  output logic [bfa_pkg::BYTES_W-1:0]  total_bytes_o,
  output logic [bfa_pkg::BYTES_W-1:0]  free_bytes_o
);
  import bfa_pkg::*;

  bfa_q_t  q;
  bfa_bk_t bk;

  bfa_front u_front (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .command_i,
    .region_base_i,
    .region_length_i,
    .region_type_i,
    .free_address_i,
    .bk_i (bk),
    .q_o  (q)
  );

  bfa_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i (cfg_reserve_low_frames_i),
    .q_i        (q),
    .bk_o       (bk),
    .result_valid_o,
    .status_o,
    .frame_address_o,
    .total_bytes_o,
    .free_bytes_o
  );

endmodule

/* sv/bfa_front.sv */
// Front end: accepts commands, decodes region bounds and free targets into
// frame numbers, and holds them in a two-entry queue. Uses bfa_pkg.
module bfa_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [bfa_pkg::CMD_W-1:0]  command_i,
  input  logic [bfa_pkg::XLEN-1:0]   region_base_i,
  input  logic [bfa_pkg::XLEN-1:0]   region_length_i,
  input  logic [bfa_pkg::TYPE_W-1:0] region_type_i,
  input  logic [bfa_pkg::XLEN-1:0]   free_address_i,
  input  bfa_pkg::bfa_bk_t          bk_i,
  output bfa_pkg::bfa_q_t           q_o
);
  import bfa_pkg::*;

  localparam int unsigned SF_W = XLEN - PAGE_SHIFT + 1;

  logic [SF_W-1:0]  start_full;
  logic [XLEN:0]    end_sum;
  logic [CNT_W-1:0] stop_fr;
  logic [CNT_W-1:0] start_fr;
  logic             start_ok;
  bfa_cmd_t         cmd;
  logic             push;

  bfa_cmd_t fifo_q [2];
  logic     wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  // Round the base up to a frame boundary; the end rounds down.
  assign start_full = {1'b0, region_base_i[XLEN-1:PAGE_SHIFT]}
                      + SF_W'(|region_base_i[PAGE_SHIFT-1:0]);
  assign end_sum    = {1'b0, region_base_i} + {1'b0, region_length_i};
  assign start_ok   = ~|start_full[SF_W-1:FRAME_W];
  assign start_fr   = start_full[CNT_W-1:0];
  assign stop_fr    = (end_sum[XLEN] || (|end_sum[XLEN-1:PAGE_SHIFT+FRAME_W]))
                      ? CNT_W'(NUM_FRAMES)
                      : {1'b0, end_sum[PAGE_SHIFT+FRAME_W-1:PAGE_SHIFT]};

  always_comb begin
    cmd.op          = command_i;
    cmd.usable      = (region_type_i == USABLE_TYPE);
    cmd.range_ok    = cmd.usable && start_ok && (start_fr < stop_fr);
    cmd.start_frame = start_fr;
    cmd.stop_frame  = stop_fr;
    cmd.free_ok     = ~|free_address_i[XLEN-1:PAGE_SHIFT+FRAME_W];
    cmd.free_frame  = free_address_i[PAGE_SHIFT+FRAME_W-1:PAGE_SHIFT];
  end

  assign busy  = (cnt_q == 2'd2) || !bk_i.init_done;
  assign push  = start && !busy;
  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.cmd   = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (bk_i.pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(bk_i.pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd;
  end

endmodule

/* sv/bfa_back.sv */
// Back end: owns the frame bitmap memory and counters, sweeps the map a
// 64-bit word per cycle for commands that touch it and registers the result.
// Uses bfa_pkg.
module bfa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bfa_pkg::CFG_W-1:0]   cfg_data_i,
  input  bfa_pkg::bfa_q_t            q_i,
  output bfa_pkg::bfa_bk_t           bk_o,
  output logic                       result_valid_o,
  output logic [bfa_pkg::STAT_W-1:0]  status_o,
  output logic [bfa_pkg::ADDR_W-1:0]  frame_address_o,
  output logic [bfa_pkg::BYTES_W-1:0] total_bytes_o,
  output logic [bfa_pkg::BYTES_W-1:0] free_bytes_o
);
  import bfa_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  function automatic logic [WORD_W-1:0] range_mask(input logic [WIDX_W-1:0] w,
                                                   input logic [CNT_W-1:0] lo,
                                                   input logic [CNT_W-1:0] hi);
    logic [WORD_W-1:0] m;
    logic [CNT_W-1:0]  f;
    for (int b = 0; b < WORD_W; b++) begin
      f    = {1'b0, w, WORD_SEL_W'(b)};
      m[b] = (f >= lo) && (f < hi);
    end
    return m;
  endfunction

  function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int b = 0; b < WORD_W; b++) n = n + POP_W'(v[b]);
    return n;
  endfunction

  function automatic logic [WORD_SEL_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_SEL_W-1:0] idx;
    idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (v[b]) idx = WORD_SEL_W'(b);
    end
    return idx;
  endfunction

  logic [2:0]          state_q, state_d;
  logic                init_done_q, init_done_d;
  logic [WIDX_W-1:0]   cur_q, cur_d, last_q, last_d;
  logic [CMD_W-1:0]    op_q, op_d;
  logic [CNT_W-1:0]    start_q, start_d, stop_q, stop_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [CNT_W-1:0]    total_q, total_d, used_q, used_d;
  logic [CFG_W-1:0]    reserve_q;
  logic [STAT_W-1:0]   stat_q, stat_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;

  logic [WORD_W-1:0]   bitmap_mem [NUM_WORDS];
  logic [WORD_W-1:0]   rdata_q;
  logic                we;
  logic [WIDX_W-1:0]   wa, ra;
  logic [WORD_W-1:0]   wd;

  logic [CNT_W-1:0]    lim;
  logic [CNT_W-1:0]    stop_m1, total_m1;
  logic [WORD_W-1:0]   tmask, avail, fin_word;
  logic [WORD_SEL_W-1:0] low_idx;
  logic [CNT_W-1:0]    free_frames;
  logic                pop;

  assign lim      = (reserve_q > CNT_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : reserve_q;
  assign stop_m1  = q_i.cmd.stop_frame - CNT_W'(1);
  assign total_m1 = total_q - CNT_W'(1);
  assign tmask    = range_mask(cur_q, '0, total_q);
  assign avail    = ~rdata_q & tmask;
  assign low_idx  = lowest_set(avail);
  assign fin_word = rdata_q | range_mask(cur_q, '0, lim);
  assign ra       = (state_q == S_RUN) ? cur_q + WIDX_W'(1) : cur_q;

  assign cfg_ready_o    = 1'b1;
  assign bk_o.pop       = pop;
  assign bk_o.init_done = init_done_q;

  always_comb begin
    state_d     = state_q;
    init_done_d = init_done_q;
    cur_d       = cur_q;
    last_d      = last_q;
    op_d        = op_q;
    start_d     = start_q;
    stop_d      = stop_q;
    frame_d     = frame_q;
    total_d     = total_q;
    used_d      = used_q;
    stat_d      = stat_q;
    addr_d      = addr_q;
    pop         = 1'b0;
    we          = 1'b0;
    wa          = cur_q;
    wd          = rdata_q;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wd    = '1;
        cur_d = cur_q + WIDX_W'(1);
        if (cur_q == WIDX_W'(NUM_WORDS - 1)) begin
          init_done_d = 1'b1;
          state_d     = init_done_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_i.valid) begin
          pop     = 1'b1;
          op_d    = q_i.cmd.op;
          start_d = q_i.cmd.start_frame;
          stop_d  = q_i.cmd.stop_frame;
          frame_d = q_i.cmd.free_frame;
          stat_d  = ST_DONE;
          addr_d  = '0;
          state_d = S_DONE;
          unique case (q_i.cmd.op)
            CMD_BEGIN: begin
              total_d = '0;
              used_d  = '0;
              cur_d   = '0;
              state_d = S_CLEAR;
            end
            CMD_ADD: begin
              if (q_i.cmd.usable && (q_i.cmd.stop_frame > total_q)) begin
                total_d = q_i.cmd.stop_frame;
              end
              if (q_i.cmd.range_ok) begin
                cur_d   = q_i.cmd.start_frame[FRAME_W-1:WORD_SEL_W];
                last_d  = stop_m1[FRAME_W-1:WORD_SEL_W];
                state_d = S_PRIME;
              end
            end
            CMD_FINISH: begin
              cur_d   = '0;
              last_d  = '1;
              used_d  = '0;
              state_d = S_PRIME;
            end
            CMD_ALLOC: begin
              if (total_q == '0) begin
                stat_d = ST_NO_FRAME;
              end else begin
                cur_d   = '0;
                last_d  = total_m1[FRAME_W-1:WORD_SEL_W];
                state_d = S_PRIME;
              end
            end
            CMD_FREE: begin
              if (q_i.cmd.free_ok && ({1'b0, q_i.cmd.free_frame} < total_q)) begin
                cur_d   = q_i.cmd.free_frame[FRAME_W-1:WORD_SEL_W];
                last_d  = q_i.cmd.free_frame[FRAME_W-1:WORD_SEL_W];
                state_d = S_PRIME;
              end else begin
                stat_d = ST_IGNORED;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PRIME: state_d = S_RUN;
      S_RUN: begin
        cur_d = cur_q + WIDX_W'(1);
        unique case (op_q)
          CMD_ADD: begin
            we = 1'b1;
            wd = rdata_q & ~range_mask(cur_q, start_q, stop_q);
            if (cur_q == last_q) state_d = S_DONE;
          end
          CMD_FINISH: begin
            we     = 1'b1;
            wd     = fin_word;
            used_d = used_q + CNT_W'(popcount(fin_word & tmask));
            if (cur_q == last_q) state_d = S_DONE;
          end
          CMD_ALLOC: begin
            if (avail != '0) begin
              we      = 1'b1;
              wd      = rdata_q | (WORD_W'(1) << low_idx);
              addr_d  = {cur_q, low_idx, {PAGE_SHIFT{1'b0}}};
              if (used_q < CNT_W'(NUM_FRAMES)) used_d = used_q + CNT_W'(1);
              state_d = S_DONE;
            end else if (cur_q == last_q) begin
              stat_d  = ST_NO_FRAME;
              state_d = S_DONE;
            end
          end
          CMD_FREE: begin
            if (rdata_q[frame_q[WORD_SEL_W-1:0]]) begin
              we = 1'b1;
              wd = rdata_q & ~(WORD_W'(1) << frame_q[WORD_SEL_W-1:0]);
              if (used_q != '0) used_d = used_q - CNT_W'(1);
            end else begin
              stat_d = ST_IGNORED;
            end
            state_d = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign free_frames = (total_q > used_q) ? total_q - used_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      init_done_q    <= 1'b0;
      cur_q          <= '0;
      op_q           <= CMD_BEGIN;
      total_q        <= '0;
      used_q         <= '0;
      reserve_q      <= RESERVE_RESET;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      init_done_q    <= init_done_d;
      cur_q          <= cur_d;
      op_q           <= op_d;
      total_q        <= total_d;
      used_q         <= used_d;
      if (cfg_valid_i) reserve_q <= cfg_data_i;
      result_valid_o <= (state_q == S_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    last_q  <= last_d;
    start_q <= start_d;
    stop_q  <= stop_d;
    frame_q <= frame_d;
    stat_q  <= stat_d;
    addr_q  <= addr_d;
    if (state_q == S_DONE) begin
      status_o        <= stat_q;
      frame_address_o <= addr_q;
      total_bytes_o   <= {total_q, {PAGE_SHIFT{1'b0}}};
      free_bytes_o    <= {free_frames, {PAGE_SHIFT{1'b0}}};
    end
  end

  // Bitmap word memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) bitmap_mem[wa] <= wd;
    rdata_q <= bitmap_mem[ra];
  end

endmodule

/* sv/bfa_checker.sv */
// Port-level checks on the result channel of the bitmap frame allocator,
// bound to the top level. Uses bfa_pkg and bitmap_frame_allocator_top_assert.svh.
`include "bitmap_frame_allocator_top_assert.svh"

module bfa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        result_valid_o,
  input logic [bfa_pkg::STAT_W-1:0]   status_o,
  input logic [bfa_pkg::ADDR_W-1:0]   frame_address_o,
  input logic [bfa_pkg::BYTES_W-1:0]  total_bytes_o,
  input logic [bfa_pkg::BYTES_W-1:0]  free_bytes_o
);
  import bfa_pkg::*;

  // One command at a time in the back: results never come back to back.
  `BFA_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o)
  `BFA_ASSERT_HOLDS(a_fail_no_addr, result_valid_o && status_o != ST_DONE, frame_address_o == '0)
  `BFA_ASSERT_HOLDS(a_free_in_total, result_valid_o, free_bytes_o <= total_bytes_o)
  `BFA_ASSERT_HOLDS(a_status_code, result_valid_o, status_o == ST_DONE || status_o == ST_NO_FRAME || status_o == ST_IGNORED)
  `BFA_ASSERT_HOLDS(a_page_aligned, result_valid_o, frame_address_o[PAGE_SHIFT-1:0] == '0)

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (.*);
